// File: hdl/h4df_pkg.sv
// ----------------------------------------------------------------------------
// H4 deframer package
// Shared types and codes for the H4 packet deframer.
// ----------------------------------------------------------------------------
package h4df_pkg;

  localparam logic [7:0] TYPE_EVT = 8'h04;
  localparam logic [7:0] TYPE_ACL = 8'h02;
  localparam logic [7:0] TYPE_SCO = 8'h03;
  localparam logic [7:0] HW_ERROR_CODE = 8'h10;

  localparam logic [1:0] PH_TYPE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  localparam logic [1:0] KIND_EVT = 2'd0;
  localparam logic [1:0] KIND_ACL = 2'd1;
  localparam logic [1:0] KIND_SCO = 2'd2;

  localparam logic REG_DROP_ENABLE = 1'b0;
  localparam logic REG_DROP_CODE   = 1'b1;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned LEN_W = 17;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       last;
    logic [1:0] kind;
    logic       run_last;
  } result_t;

endpackage

// File: hdl/h4_packet_deframer.sv
// ----------------------------------------------------------------------------
// H4 packet deframer
// Splits a raw byte stream into H4 event, ACL and SCO packets with markers.
// ----------------------------------------------------------------------------
// Results of a byte are registered into the result queue behind earlier results.
// Throughput: one byte per cycle while in_stall is low; an event code yields
// two results, buffered in a four-entry result queue, so in_stall rises only
// when it holds 3 or more. Reset: parser returns to type search, queue empties,
// drop_enable = 1 and drop_event_code = 0x10.
module h4_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_packet_start,
  output logic        out_packet_end,
  output logic [1:0]  out_packet_kind,
  output logic        out_run_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import h4df_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic             drop_en_r;
  logic [7:0]       drop_code_r;
  logic [1:0]       phase_r, phase_nxt;
  logic [2:0]       hdr_cnt_r, hdr_cnt_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic [7:0]       held_type_r, held_type_nxt;
  logic [7:0]       len_low_r, len_low_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic             discard_r, discard_nxt;

  result_t          q_r [QUEUE_DEPTH];
  result_t          q_nxt [QUEUE_DEPTH];
  result_t          q_shift [QUEUE_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] base;

  result_t          res0, res1;
  logic [1:0]       n_res;
  logic             in_xfer, out_xfer, cfg_wr;
  logic [7:0]       b;
  logic [LEN_W-1:0] len;
  logic             len_set;
  logic             disc_cur;
  logic [LEN_W-1:0] bl_dec;

  assign pready   = 1'b1;
  assign cfg_wr   = psel & penable & pwrite;
  assign in_stall = (count_r > CNT_W'(QUEUE_DEPTH - 2));
  assign in_xfer  = in_valid & ~in_stall;
  assign out_valid = (count_r != '0);
  assign out_xfer  = out_valid & ~out_stall;
  assign b = in_rx_byte;

  assign out_byte         = q_r[0].data;
  assign out_packet_start = q_r[0].start;
  assign out_packet_end   = q_r[0].last;
  assign out_packet_kind  = q_r[0].kind;
  assign out_run_last     = q_r[0].run_last;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_DROP_ENABLE: prdata = {31'd0, drop_en_r};
      REG_DROP_CODE:   prdata = {24'd0, drop_code_r};
      default:         prdata = '0;
    endcase
  end

  // parser
  always_comb begin
    phase_nxt      = phase_r;
    hdr_cnt_nxt    = hdr_cnt_r;
    kind_nxt       = kind_r;
    held_type_nxt  = held_type_r;
    len_low_nxt    = len_low_r;
    bytes_left_nxt = bytes_left_r;
    discard_nxt    = discard_r;
    n_res          = 2'd0;
    res0           = '{data: b, start: 1'b0, last: 1'b0, kind: kind_r, run_last: 1'b0};
    res1           = '{data: b, start: 1'b0, last: 1'b0, kind: kind_r, run_last: 1'b1};
    len            = '0;
    len_set        = 1'b0;
    disc_cur       = 1'b0;
    bl_dec         = bytes_left_r - LEN_W'(1);

    if (phase_r == PH_HEADER && kind_r <= KIND_SCO) begin
      hdr_cnt_nxt = hdr_cnt_r + 3'd1;
      unique case (kind_r)
        KIND_EVT: begin
          if (hdr_cnt_r <= 3'd1) begin
            disc_cur    = drop_en_r & (b == drop_code_r);
            discard_nxt = disc_cur;
            if (!disc_cur) begin
              n_res      = 2'd2;
              res0.data  = held_type_r;
              res0.start = 1'b1;
            end
          end else begin
            len     = LEN_W'(b);
            len_set = 1'b1;
          end
        end
        KIND_ACL: begin
          if (hdr_cnt_r <= 3'd2) begin
            n_res = 2'd1;
          end else if (hdr_cnt_r == 3'd3) begin
            len_low_nxt = b;
            n_res       = 2'd1;
          end else begin
            len     = LEN_W'({b, len_low_r});
            len_set = 1'b1;
          end
        end
        default: begin
          if (hdr_cnt_r <= 3'd2) begin
            n_res = 2'd1;
          end else begin
            len     = LEN_W'(b);
            len_set = 1'b1;
          end
        end
      endcase
      if (len_set) begin
        bytes_left_nxt = len;
        if (!discard_r) begin
          n_res     = 2'd1;
          res0.last = (len == '0);
        end
        if (len == '0) begin
          phase_nxt   = PH_TYPE;
          discard_nxt = 1'b0;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
    end else if (phase_r == PH_PAYLOAD && kind_r <= KIND_SCO) begin
      bytes_left_nxt = bl_dec;
      if (!discard_r) begin
        n_res     = 2'd1;
        res0.last = (bl_dec == '0);
      end
      if (bl_dec == '0) begin
        phase_nxt   = PH_TYPE;
        discard_nxt = 1'b0;
      end
    end else begin
      phase_nxt   = PH_TYPE;
      discard_nxt = 1'b0;
      if (b == TYPE_EVT) begin
        kind_nxt      = KIND_EVT;
        held_type_nxt = b;
        hdr_cnt_nxt   = 3'd1;
        phase_nxt     = PH_HEADER;
      end else if (b == TYPE_ACL || b == TYPE_SCO) begin
        kind_nxt    = (b == TYPE_ACL) ? KIND_ACL : KIND_SCO;
        hdr_cnt_nxt = 3'd1;
        phase_nxt   = PH_HEADER;
        n_res       = 2'd1;
        res0.start  = 1'b1;
        res0.kind   = kind_nxt;
      end
    end
    res0.run_last = (n_res == 2'd1);
  end

  // result queue: shift on transfer out, append behind the survivors
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
      q_shift[i] = out_xfer ? q_r[i+1] : q_r[i];
    end
    q_shift[QUEUE_DEPTH-1] = q_r[QUEUE_DEPTH-1];
    base = count_r - CNT_W'(out_xfer);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_shift[i];
      if (in_xfer && n_res != 2'd0 && base == CNT_W'(i)) begin
        q_nxt[i] = res0;
      end
      if (in_xfer && n_res == 2'd2 && base + CNT_W'(1) == CNT_W'(i)) begin
        q_nxt[i] = res1;
      end
    end
    count_nxt = base + (in_xfer ? CNT_W'(n_res) : CNT_W'(0));
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
    if (!rst_n) begin
      count_r      <= '0;
      drop_en_r    <= 1'b1;
      drop_code_r  <= HW_ERROR_CODE;
      phase_r      <= PH_TYPE;
      hdr_cnt_r    <= '0;
      kind_r       <= KIND_EVT;
      held_type_r  <= '0;
      len_low_r    <= '0;
      bytes_left_r <= '0;
      discard_r    <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg_wr) begin
        unique case (paddr[2])
          REG_DROP_ENABLE: drop_en_r   <= pwdata[0];
          REG_DROP_CODE:   drop_code_r <= pwdata[7:0];
          default:         drop_en_r   <= drop_en_r;
        endcase
      end
      if (in_xfer) begin
        phase_r      <= phase_nxt;
        hdr_cnt_r    <= hdr_cnt_nxt;
        kind_r       <= kind_nxt;
        held_type_r  <= held_type_nxt;
        len_low_r    <= len_low_nxt;
        bytes_left_r <= bytes_left_nxt;
        discard_r    <= discard_nxt;
      end
    end
  end

endmodule
